FILE: design/scq_pkg.sv
package scq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [7:0] CODE_LIMIT     = 8'h57;
    localparam logic [7:0] CODE_ENTER     = 8'h1C;
    localparam logic [7:0] CODE_BACKSPACE = 8'h0E;
    localparam logic [7:0] TABLE_SPAN     = 8'd58;
    localparam logic [7:0] RELEASE_BIT    = 8'h80;
    localparam logic [7:0] LEFT_SHIFT     = 8'h2A;
    localparam logic [7:0] RIGHT_SHIFT    = 8'h36;

    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_INVALID   = 8'hFF;
    localparam logic [7:0] CHAR_NONE      = 8'h00;

    typedef struct packed {
        logic [7:0] ascii;
        logic       press;
        logic [7:0] raw_code;
    } rec_t;

    typedef struct packed {
        logic is_read;
        rec_t rec;
    } cmd_t;

    localparam int REC_W = $bits(rec_t);

    // entries past the table span are padding, never selected
    localparam logic [7:0] PLAIN_MAP [0:63] = '{
        8'h3F, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h3F, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] SHIFTED_MAP [0:63] = '{
        8'h3F, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h3F, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    function automatic logic [7:0] decode_char(logic [7:0] code, logic shifted);
        logic [7:0] ch;
        if (code > CODE_LIMIT)
            ch = CHAR_INVALID;
        else if (code == CODE_ENTER)
            ch = CHAR_NEWLINE;
        else if (code == CODE_BACKSPACE)
            ch = CHAR_BACKSPACE;
        else if (code >= TABLE_SPAN)
            ch = CHAR_NONE;
        else if (shifted)
            ch = SHIFTED_MAP[code[5:0]];
        else
            ch = PLAIN_MAP[code[5:0]];
        return ch;
    endfunction

    function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            n = '0;
        else
            n = p + PTR_W'(1);
        return n;
    endfunction

endpackage

FILE: design/scq_ram.sv
module scq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/scq_front.sv
module scq_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cmd,
    input  logic [7:0]        scan_byte,
    output logic              push_valid,
    input  logic              push_ready,
    output scq_pkg::cmd_t     push_data
);

    logic       shift_reg;
    logic       shift_next;
    logic [7:0] base;
    logic       toggle;
    logic       xfer;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign xfer       = in_valid && push_ready;

    assign base   = scan_byte & ~scq_pkg::RELEASE_BIT;
    assign toggle = (base == scq_pkg::LEFT_SHIFT) || (base == scq_pkg::RIGHT_SHIFT);

    always_comb
    begin
        shift_next = shift_reg;
        if (xfer && (cmd == scq_pkg::CMD_SCAN) && toggle)
        begin
            shift_next = ~shift_reg;
        end
    end

    always_comb
    begin
        push_data.is_read      = (cmd == scq_pkg::CMD_READ);
        push_data.rec.ascii    = scq_pkg::decode_char(scan_byte, shift_next);
        push_data.rec.press    = ~scan_byte[7];
        push_data.rec.raw_code = scan_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
        end
        else
        begin
            shift_reg <= shift_next;
        end
    end

endmodule

FILE: design/scq_cmdq.sv
module scq_cmdq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  scq_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output scq_pkg::cmd_t pop_data
);

    scq_pkg::cmd_t entry_reg [0:1];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          push;
    logic          pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

FILE: design/scq_back.sv
module scq_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  scq_pkg::cmd_t cmd_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          valid_res,
    output logic [7:0]    ascii,
    output logic          press,
    output logic [7:0]    raw_code
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_FETCH = 2'b10
    } state_t;

    state_t                     state_reg, state_next;
    logic [scq_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [scq_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [scq_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       hit_reg, hit_next;
    scq_pkg::rec_t              rec_reg, rec_next;
    logic [scq_pkg::REC_W-1:0] ram_rdata;
    logic                       take;
    logic                       do_write;
    logic                       do_read;
    logic                       do_empty;
    logic                       full;
    logic                       empty;

    assign full  = (count_reg == scq_pkg::CNT_W'(scq_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    assign cmd_ready = (state_reg == ST_IDLE) && (!cmd_data.is_read || !out_valid_reg);
    assign take      = cmd_valid && cmd_ready;
    assign do_write  = take && !cmd_data.is_read;
    assign do_read   = take && cmd_data.is_read && !empty;
    assign do_empty  = take && cmd_data.is_read && empty;

    scq_ram #(
        .WIDTH (scq_pkg::REC_W),
        .DEPTH (scq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (do_write),
        .waddr (wr_ptr_reg),
        .wdata (cmd_data.rec),
        .re    (do_read),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        rec_next       = rec_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (do_write)
                begin
                    wr_ptr_next = scq_pkg::next_ptr(wr_ptr_reg);
                    // full: drop the oldest record
                    if (full)
                        rd_ptr_next = scq_pkg::next_ptr(rd_ptr_reg);
                    else
                        count_next = count_reg + scq_pkg::CNT_W'(1);
                end
                else if (do_read)
                begin
                    rd_ptr_next = scq_pkg::next_ptr(rd_ptr_reg);
                    count_next  = count_reg - scq_pkg::CNT_W'(1);
                    state_next  = ST_FETCH;
                end
                else if (do_empty)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = 1'b0;
                    rec_next       = '0;
                end
            end
            ST_FETCH:
            begin
                out_valid_next = 1'b1;
                hit_next       = 1'b1;
                rec_next       = scq_pkg::rec_t'(ram_rdata);
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        rec_reg <= rec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign valid_res = hit_reg;
    assign ascii     = rec_reg.ascii;
    assign press     = rec_reg.press;
    assign raw_code  = rec_reg.raw_code;

endmodule

FILE: design/scancode_to_ascii_queue.sv
// Set-1 keyboard scancode decoder with a 64-entry record queue. A transfer with
// cmd = 0 decodes scan_byte (shift keys toggle the shift state) and queues
// {ascii, press, raw_code}; when the queue is full the oldest record is dropped.
// A transfer with cmd = 1 returns one result: the oldest record with
// valid_res = 1, or all-zero fields with valid_res = 0 when the queue is empty.
// The front accepts one transfer per cycle while its two-entry command buffer
// has room. The back retires a scancode or an empty read from its idle state;
// a read that pops a record passes through a fetch state (registered read of
// the record RAM). Any read waits in the buffer until the prior result is taken.
module scancode_to_ascii_queue (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [7:0] scan_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       valid_res,
    output logic [7:0] ascii,
    output logic       press,
    output logic [7:0] raw_code
);

    logic          push_valid;
    logic          push_ready;
    scq_pkg::cmd_t push_data;
    logic          pop_valid;
    logic          pop_ready;
    scq_pkg::cmd_t pop_data;

    scq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .scan_byte  (scan_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    scq_cmdq u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    scq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .valid_res (valid_res),
        .ascii     (ascii),
        .press     (press),
        .raw_code  (raw_code)
    );

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> ascii == 8'h00 && !press && raw_code == 8'h00)
        else $error("empty read carries nonzero fields");

    a_press_bit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> press == !raw_code[7])
        else $error("press flag does not match raw code");

    a_release_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res && raw_code > scq_pkg::CODE_LIMIT
        |-> ascii == scq_pkg::CHAR_INVALID)
        else $error("out-of-range code not decoded as invalid");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int END_SETTLE  = 20;

    typedef struct packed {
        logic          valid_res;
        scq_pkg::rec_t rec;
    } read_result_t;

    localparam logic [7:0] PLAIN_CHARS [0:57] = '{
        8'h3F, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
        8'h2D, 8'h3D, 8'h00, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68,
        8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27, 8'h60, 8'h3F, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    localparam logic [7:0] SHIFT_CHARS [0:57] = '{
        8'h3F, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
        8'h5F, 8'h2B, 8'h00, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48,
        8'h4A, 8'h4B, 8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h3F, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       cmd;
    logic [7:0] scan_byte;
    logic       out_valid;
    logic       out_ready;
    logic       valid_res;
    logic [7:0] ascii;
    logic       press;
    logic [7:0] raw_code;

    // predictor state
    logic          shift_on;
    scq_pkg::rec_t key_records[$];
    read_result_t  expected_reads[$];

    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;
    int mismatch_count;
    int scans_sent;
    int reads_sent;
    int records_popped;
    int empty_reads;
    int records_dropped;
    int results_checked;

    scancode_to_ascii_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .scan_byte (scan_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .valid_res (valid_res),
        .ascii     (ascii),
        .press     (press),
        .raw_code  (raw_code)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic logic [7:0] lookup_char(logic [7:0] code, logic shifted);
        if (code > scq_pkg::CODE_LIMIT)
            return scq_pkg::CHAR_INVALID;
        if (code == scq_pkg::CODE_ENTER)
            return scq_pkg::CHAR_NEWLINE;
        if (code == scq_pkg::CODE_BACKSPACE)
            return scq_pkg::CHAR_BACKSPACE;
        if (code >= scq_pkg::TABLE_SPAN)
            return scq_pkg::CHAR_NONE;
        return shifted ? SHIFT_CHARS[code[5:0]] : PLAIN_CHARS[code[5:0]];
    endfunction

    function automatic void predict_transfer(logic op, logic [7:0] code);
        scq_pkg::rec_t r;
        read_result_t  res;
        if (op == scq_pkg::CMD_SCAN)
        begin
            scans_sent++;
            if ((code & ~scq_pkg::RELEASE_BIT) == scq_pkg::LEFT_SHIFT
                || (code & ~scq_pkg::RELEASE_BIT) == scq_pkg::RIGHT_SHIFT)
                shift_on = ~shift_on;
            r.ascii    = lookup_char(code, shift_on);
            r.press    = ((code & scq_pkg::RELEASE_BIT) == 8'h00);
            r.raw_code = code;
            if (key_records.size() >= scq_pkg::QUEUE_DEPTH)
            begin
                void'(key_records.pop_front());
                records_dropped++;
            end
            key_records.push_back(r);
        end
        else
        begin
            reads_sent++;
            res = '0;
            if (key_records.size() != 0)
            begin
                res.valid_res = 1'b1;
                res.rec       = key_records.pop_front();
                records_popped++;
            end
            else
                empty_reads++;
            expected_reads.push_back(res);
        end
    endfunction

    function automatic void check_field(string field_name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field_name, want, got);
        end
    endfunction

    // transfers are predicted before results are checked at the same edge
    always @(posedge clk)
    begin : monitor
        read_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_transfer(cmd, scan_byte);
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (expected_reads.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual %0b %02h %0b %02h",
                             $time, valid_res, ascii, press, raw_code);
                end
                else
                begin
                    want = expected_reads.pop_front();
                    check_field("valid_res", 8'(want.valid_res), 8'(valid_res));
                    check_field("ascii", want.rec.ascii, ascii);
                    check_field("press", 8'(want.rec.press), 8'(press));
                    check_field("raw_code", want.rec.raw_code, raw_code);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_reads.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [7:0] code);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        cmd       <= op;
        scan_byte <= code;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_reads.size() != 0);
    endtask

    function automatic logic [7:0] pick_scan_code();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            case ($urandom_range(3))
                0: return scq_pkg::LEFT_SHIFT;
                1: return scq_pkg::RIGHT_SHIFT;
                2: return scq_pkg::LEFT_SHIFT | scq_pkg::RELEASE_BIT;
                default: return scq_pkg::RIGHT_SHIFT | scq_pkg::RELEASE_BIT;
            endcase
        end
        if (pick < 65)
            return 8'($urandom_range(0, scq_pkg::CODE_LIMIT));
        if (pick < 80)
            return 8'($urandom_range(0, scq_pkg::CODE_LIMIT)) | scq_pkg::RELEASE_BIT;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic test_special_codes();
        logic [7:0] codes [14] = '{
            8'h00, scq_pkg::CODE_ENTER, scq_pkg::CODE_BACKSPACE, 8'h39, 8'h3A,
            scq_pkg::CODE_LIMIT, 8'h58, 8'hFF, scq_pkg::LEFT_SHIFT, 8'h10,
            scq_pkg::LEFT_SHIFT | scq_pkg::RELEASE_BIT, scq_pkg::RIGHT_SHIFT, 8'h02,
            scq_pkg::RIGHT_SHIFT | scq_pkg::RELEASE_BIT
        };
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(scq_pkg::CMD_READ, 8'hA5);
        foreach (codes[i])
            send_item(scq_pkg::CMD_SCAN, codes[i]);
        repeat (11)
            send_item(scq_pkg::CMD_READ, 8'h5A);
        wait_for_results();
    endtask

    task automatic test_queue_overflow();
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        repeat (scq_pkg::QUEUE_DEPTH + 8)
            send_item(scq_pkg::CMD_SCAN, pick_scan_code());
        repeat (scq_pkg::QUEUE_DEPTH + 4)
            send_item(scq_pkg::CMD_READ, 8'($urandom_range(0, 255)));
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct);
        int read_pct;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        read_pct       = 50;
        for (int n = 0; n < items; n++)
        begin
            // bursts lean toward writes or reads so the queue swings full and empty
            if (n % 30 == 0)
            begin
                case ($urandom_range(2))
                    0: read_pct = 15;
                    1: read_pct = 50;
                    default: read_pct = 85;
                endcase
            end
            if ($urandom_range(99) < read_pct)
                send_item(scq_pkg::CMD_READ, 8'($urandom_range(0, 255)));
            else
                send_item(scq_pkg::CMD_SCAN, pick_scan_code());
        end
        wait_for_results();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        cmd             = scq_pkg::CMD_SCAN;
        scan_byte       = 8'h00;
        out_ready       = 1'b0;
        shift_on        = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        cycle_count     = 0;
        mismatch_count  = 0;
        scans_sent      = 0;
        reads_sent      = 0;
        records_popped  = 0;
        empty_reads     = 0;
        records_dropped = 0;
        results_checked = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_codes();
        test_queue_overflow();
        test_random_traffic(420, 0, 0);
        test_random_traffic(420, 65, 0);
        test_random_traffic(420, 0, 65);
        test_random_traffic(420, 30, 30);

        repeat (END_SETTLE) @(posedge clk);
        $display("Sent %0d scancodes and %0d reads: %0d records popped, %0d empty reads,",
                 scans_sent, reads_sent, records_popped, empty_reads);
        $display("%0d records dropped on a full queue, %0d results checked, %0d mismatches",
                 records_dropped, results_checked, mismatch_count);
        if (mismatch_count == 0 && expected_reads.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
design/scq_pkg.sv
design/scq_ram.sv
design/scq_front.sv
design/scq_cmdq.sv
design/scq_back.sv
design/scancode_to_ascii_queue.sv
sim/testbench.sv
